// ===== rtl/mtes_pkg.sv =====
// ----------------------------------------------------------------------------
// mtes_pkg
// Shared types and constants for the MIDI track event serializer: payload
// layouts, event codes, status bytes and the delta-time digit geometry.
// ----------------------------------------------------------------------------
package mtes_pkg;

   // Field widths
   localparam int ACTION_W = 2;
   localparam int DELTA_W  = 28;
   localparam int NOTE_W   = 7;
   localparam int VEL_W    = 7;
   localparam int TEMPO_W  = 24;
   localparam int BYTE_W   = 8;

   // Variable-length quantity geometry: 7-bit digits, at most four of them
   localparam int VLQ_DIGIT_W    = 7;
   localparam int VLQ_MAX_DIGITS = DELTA_W / VLQ_DIGIT_W;
   localparam int VLQ_CNT_W      = $clog2(VLQ_MAX_DIGITS + 1);

   // Event body: at most six bytes (meta tempo)
   localparam int BODY_MAX_BYTES = 6;
   localparam int BODY_W         = BODY_MAX_BYTES * BYTE_W;
   localparam int BODY_CNT_W     = $clog2(BODY_MAX_BYTES + 1);

   // Event codes
   typedef enum logic [ACTION_W-1:0] {
      ACTION_NOTE_ON  = 2'd0,
      ACTION_NOTE_OFF = 2'd1,
      ACTION_TEMPO    = 2'd2
   } action_type;

   // Track bytes
   localparam logic [BYTE_W-1:0] STATUS_NOTE_ON  = 8'h90;
   localparam logic [BYTE_W-1:0] STATUS_NOTE_OFF = 8'h80;
   localparam logic [BYTE_W-1:0] NOTE_OFF_VEL    = 8'h40;
   localparam logic [BYTE_W-1:0] META_PREFIX     = 8'hFF;
   localparam logic [BYTE_W-1:0] META_TEMPO      = 8'h51;
   localparam logic [BYTE_W-1:0] META_TEMPO_LEN  = 8'h03;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [DELTA_W-1:0]  delta_ticks;
      logic [NOTE_W-1:0]   note_number;
      logic [VEL_W-1:0]    note_velocity;
      logic [TEMPO_W-1:0]  tempo_us_per_beat;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              last_byte;
   } rsp_payload_type;

   // Control from the sequencer to the delta-time shifter
   typedef struct packed {
      logic load;
      logic shift;
   } vlq_ctrl_type;

   // Status from the delta-time shifter
   typedef struct packed {
      logic [BYTE_W-1:0] vlq_byte;
      logic              final_digit;
   } vlq_status_type;

endpackage

// ===== rtl/mtes_if.sv =====
// ----------------------------------------------------------------------------
// mtes_req_if / mtes_rsp_if
// Valid/ready channels for event requests and serialized track bytes.
// ----------------------------------------------------------------------------
interface mtes_req_if;
   import mtes_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mtes_rsp_if;
   import mtes_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/midi_track_event_serializer_core.sv =====
// ----------------------------------------------------------------------------
// midi_track_event_serializer_core
// Turns one track event request into Standard MIDI File track bytes: the
// delta time as a variable-length quantity, then the event body.
// Taking a request enters the delta state, which registers the first byte.
// Throughput: one byte per cycle while the sink is ready; an event is 1+3 to
// 4+6 bytes (4 to 10), plus the idle state in which the request is taken.
// The byte sequencer handles one event at a time; the next request is taken
// once the final byte has been registered, even while that byte still waits.
// An undefined event code is accepted and produces no bytes.
// Reset (synchronous, active high) clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module midi_track_event_serializer_core (
   input  logic        clock,
   input  logic        reset,
   mtes_req_if.sink    req_bus,
   mtes_rsp_if.source  rsp_bus
);
   import mtes_pkg::*;

   // One-hot sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_VLQ  = 3'b010,
      ST_BODY = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [BODY_W-1:0]      body_ff, body_in;
   logic [BODY_CNT_W-1:0]  body_cnt_ff, body_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]      rsp_byte_ff, rsp_byte_in;
   logic                   rsp_last_ff, rsp_last_in;

   vlq_ctrl_type   vlq_ctrl;
   vlq_status_type vlq_status;

   logic req_fire;
   logic advance;
   logic known_action;
   logic body_final;

   mtes_vlq_shifter u_vlq (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (vlq_ctrl),
      .delta  (req_bus.payload.delta_ticks),
      .status (vlq_status)
   );

   // Take a new request only between events
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;

   // The output register may load when empty or when its byte is leaving
   assign advance = !rsp_valid_ff || rsp_bus.ready;

   assign known_action = (req_bus.payload.action == ACTION_NOTE_ON)
                      || (req_bus.payload.action == ACTION_NOTE_OFF)
                      || (req_bus.payload.action == ACTION_TEMPO);

   assign body_final = (body_cnt_ff == BODY_CNT_W'(1));

   always_comb begin
      state_in       = state_ff;
      body_in        = body_ff;
      body_cnt_in    = body_cnt_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_last_in    = rsp_last_ff;
      vlq_ctrl.load  = 1'b0;
      vlq_ctrl.shift = 1'b0;

      // Drop a byte once the sink takes it
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && known_action) begin
               vlq_ctrl.load = 1'b1;
               state_in      = ST_VLQ;
               // Build the body left-aligned, first byte on top
               if (req_bus.payload.action == ACTION_NOTE_ON) begin
                  body_in     = {STATUS_NOTE_ON, 1'b0, req_bus.payload.note_number,
                                 1'b0, req_bus.payload.note_velocity,
                                 (BODY_W - 3*BYTE_W)'(0)};
                  body_cnt_in = BODY_CNT_W'(3);
               end else if (req_bus.payload.action == ACTION_NOTE_OFF) begin
                  body_in     = {STATUS_NOTE_OFF, 1'b0, req_bus.payload.note_number,
                                 NOTE_OFF_VEL, (BODY_W - 3*BYTE_W)'(0)};
                  body_cnt_in = BODY_CNT_W'(3);
               end else begin
                  body_in     = {META_PREFIX, META_TEMPO, META_TEMPO_LEN,
                                 req_bus.payload.tempo_us_per_beat};
                  body_cnt_in = BODY_CNT_W'(BODY_MAX_BYTES);
               end
            end
         end
         ST_VLQ: begin
            // Emit one delta digit per cycle while not stalled, continuation bit on all but the last
            if (advance) begin
               rsp_valid_in   = 1'b1;
               rsp_byte_in    = vlq_status.vlq_byte;
               rsp_last_in    = 1'b0;
               vlq_ctrl.shift = 1'b1;
               if (vlq_status.final_digit) begin
                  state_in = ST_BODY;
               end
            end
         end
         ST_BODY: begin
            // Shift the body out a byte at a time; flag the final one
            if (advance) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = body_ff[BODY_W-1 -: BYTE_W];
               rsp_last_in  = body_final;
               body_in      = body_ff << BYTE_W;
               body_cnt_in  = body_cnt_ff - BODY_CNT_W'(1);
               if (body_final) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      body_ff     <= body_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         body_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         body_cnt_ff  <= body_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.payload.out_byte  = rsp_byte_ff;
   assign rsp_bus.payload.last_byte = rsp_last_ff;

endmodule

// ===== rtl/mtes_vlq_shifter.sv =====
// ----------------------------------------------------------------------------
// mtes_vlq_shifter
// Delta-time shifter: left-aligns the delta on its leading nonzero 7-bit digit
// (one zero digit if zero) and hands out one VLQ byte per shift, MSB first.
// ----------------------------------------------------------------------------
module mtes_vlq_shifter (
   input  logic                          clock,
   input  logic                          reset,
   input  mtes_pkg::vlq_ctrl_type        ctrl,
   input  logic [mtes_pkg::DELTA_W-1:0]  delta,
   output mtes_pkg::vlq_status_type      status
);
   import mtes_pkg::*;

   logic [DELTA_W-1:0]   shift_ff, shift_in;
   logic [VLQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic [VLQ_CNT_W-1:0] load_cnt;
   logic [DELTA_W-1:0]   load_word;

   // Count significant digits, at least one
   always_comb begin
      load_cnt = VLQ_CNT_W'(1);
      for (int i = 1; i < VLQ_MAX_DIGITS; i++) begin
         if (delta[i*VLQ_DIGIT_W +: VLQ_DIGIT_W] != '0) begin
            load_cnt = VLQ_CNT_W'(i + 1);
         end
      end
   end

   // Left-align so the leading digit sits at the top
   always_comb begin
      load_word = delta;
      for (int i = 1; i <= VLQ_MAX_DIGITS; i++) begin
         if (load_cnt == VLQ_CNT_W'(i)) begin
            load_word = delta << ((VLQ_MAX_DIGITS - i) * VLQ_DIGIT_W);
         end
      end
   end

   always_comb begin
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      if (ctrl.load) begin
         shift_in = load_word;
         cnt_in   = load_cnt;
      end else if (ctrl.shift) begin
         shift_in = shift_ff << VLQ_DIGIT_W;
         cnt_in   = cnt_ff - VLQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign status.final_digit = (cnt_ff == VLQ_CNT_W'(1));
   assign status.vlq_byte    = {~status.final_digit,
                                shift_ff[DELTA_W-1 -: VLQ_DIGIT_W]};

endmodule

// ===== rtl/mtes_checker.sv =====
// ----------------------------------------------------------------------------
// mtes_checker
// Port-level checks for the track event serializer, bound to the top level.
// ----------------------------------------------------------------------------
module mtes_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [mtes_pkg::ACTION_W-1:0] req_action,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_last
);
   import mtes_pkg::*;

   // Hold a stalled byte
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // Once a defined event is taken, the block stops accepting requests
   a_busy_after_event: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ACTION_NOTE_ON
         || req_action == ACTION_NOTE_OFF || req_action == ACTION_TEMPO)
      |=> !req_ready)
      else $error("request taken without serializing it");

   // Between events only the final byte of the previous one can be pending
   a_idle_only_last: assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_last)
      else $error("new request possible while event bytes remain");

   // Reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind midi_track_event_serializer_core mtes_checker u_mtes_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .req_action (req_bus.payload.action),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_last   (rsp_bus.payload.last_byte)
);

// ===== verif/midi_track_event_serializer_core_tb.sv =====
// ----------------------------------------------------------------------------
// midi_track_event_serializer_core_tb
// Self-checking bench for the MIDI track event serializer. A short directed
// list covers delta and field extremes, every event kind and the undefined
// code. Random events follow, with random gaps on the request side and random
// stalls on the byte side. Every track byte is compared with expected bytes,
// typed in the directed list or from an independent encoder model.
// ----------------------------------------------------------------------------
module midi_track_event_serializer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mtes_pkg::*;

   localparam logic [ACTION_W-1:0] ACTION_UNDEFINED = 2'd3;

   localparam int MAX_EVENT_BYTES = VLQ_MAX_DIGITS + BODY_MAX_BYTES;
   localparam int RANDOM_EVENTS   = 392;
   localparam int MAX_GAP         = 9;
   localparam int DRAIN_CYCLES    = 16;
   localparam int STALL_LIMIT     = 1000;
   localparam int MAX_REPORTS     = 10;

   // One directed event. Where typed is set, the expected track bytes are
   // given right-aligned in typed_bytes, first byte in the highest position.
   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic [DELTA_W-1:0]        delta;
      logic [NOTE_W-1:0]         note;
      logic [VEL_W-1:0]          vel;
      logic [TEMPO_W-1:0]        tempo;
      logic                      typed;
      logic [3:0]                typed_count;
      logic [10*BYTE_W-1:0]      typed_bytes;
   } directed_event_type;

   localparam int NUM_DIRECTED = 18;

   localparam directed_event_type DIRECTED_EVENTS [NUM_DIRECTED] = '{
      // all-zero note on straight after reset
      '{ACTION_NOTE_ON,  28'h0000000, 7'h00, 7'h00, 24'h000000, 1'b1, 4'd4,
        80'h00_90_00_00},
      // largest delta, largest note and velocity
      '{ACTION_NOTE_ON,  28'hFFFFFFF, 7'h7F, 7'h7F, 24'hFFFFFF, 1'b1, 4'd7,
        80'hFF_FF_FF_7F_90_7F_7F},
      // note off keeps its fixed velocity whatever is requested
      '{ACTION_NOTE_OFF, 28'h0000000, 7'h7F, 7'h7F, 24'h000000, 1'b1, 4'd4,
        80'h00_80_7F_40},
      '{ACTION_TEMPO,    28'h0000000, 7'h00, 7'h00, 24'hFFFFFF, 1'b1, 4'd7,
        80'h00_FF_51_03_FF_FF_FF},
      // longest event: four delta bytes and the whole tempo body
      '{ACTION_TEMPO,    28'hFFFFFFF, 7'h7F, 7'h7F, 24'h000000, 1'b1, 4'd10,
        80'hFF_FF_FF_7F_FF_51_03_00_00_00},
      // undefined code produces nothing
      '{ACTION_UNDEFINED, 28'h0000000, 7'h00, 7'h00, 24'h000000, 1'b1, 4'd0,
        80'h0},
      '{ACTION_UNDEFINED, 28'hFFFFFFF, 7'h7F, 7'h7F, 24'hFFFFFF, 1'b1, 4'd0,
        80'h0},
      // delta length boundaries, checked by the encoder model
      '{ACTION_NOTE_ON,  28'h000007F, 7'h3C, 7'h64, 24'h123456, 1'b0, 4'd0, 80'h0},
      '{ACTION_NOTE_ON,  28'h0000080, 7'h3D, 7'h01, 24'h000000, 1'b0, 4'd0, 80'h0},
      '{ACTION_NOTE_OFF, 28'h0003FFF, 7'h40, 7'h00, 24'hFFFFFF, 1'b0, 4'd0, 80'h0},
      '{ACTION_NOTE_OFF, 28'h0004000, 7'h41, 7'h55, 24'h000000, 1'b0, 4'd0, 80'h0},
      '{ACTION_TEMPO,    28'h01FFFFF, 7'h12, 7'h34, 24'h07A120, 1'b0, 4'd0, 80'h0},
      '{ACTION_TEMPO,    28'h0200000, 7'h7F, 7'h00, 24'h000001, 1'b0, 4'd0, 80'h0},
      // alternating bit patterns in note, velocity, tempo and most deltas
      '{ACTION_NOTE_ON,  28'h5555555, 7'h55, 7'h2A, 24'h555555, 1'b0, 4'd0, 80'h0},
      '{ACTION_NOTE_OFF, 28'hAAAAAAA, 7'h2A, 7'h55, 24'hAAAAAA, 1'b0, 4'd0, 80'h0},
      '{ACTION_TEMPO,    28'h0000001, 7'h55, 7'h2A, 24'hAAAAAA, 1'b0, 4'd0, 80'h0},
      '{ACTION_UNDEFINED, 28'hAAAAAAA, 7'h2A, 7'h55, 24'h555555, 1'b0, 4'd0, 80'h0},
      // normal event right behind an undefined one
      '{ACTION_NOTE_ON,  28'h0000001, 7'h01, 7'h01, 24'h000000, 1'b0, 4'd0, 80'h0}
   };

   logic clock;
   logic reset;

   mtes_req_if req_ch ();
   mtes_rsp_if rsp_ch ();

   midi_track_event_serializer_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   // Track bytes still owed by the serializer, oldest first
   rsp_payload_type expected_track_bytes [$];

   int mismatches;
   int bytes_compared;
   int events_by_action [4];
   int delta_length_seen [VLQ_MAX_DIGITS+1];
   int send_burst_left;
   int sink_burst_left;
   int idle_cycles;

   // ------------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Append one expected byte behind the ones still owed
   function automatic void queue_expected(input rsp_payload_type item);
      expected_track_bytes = {expected_track_bytes, item};
   endfunction

   // ------------------------------------------------------------------------
   // Encoder model: delta as a big-endian VLQ, then the event body. The
   // final byte of each event carries last_byte.
   // ------------------------------------------------------------------------
   function automatic void predict_track_bytes(input req_payload_type ev);
      logic [DELTA_W-1:0]     rest;
      logic [VLQ_DIGIT_W-1:0] digits [VLQ_MAX_DIGITS];
      logic [BYTE_W-1:0]      seq [MAX_EVENT_BYTES];
      int                     ndig;
      int                     cnt;

      if (ev.action == ACTION_UNDEFINED) return;

      // split the delta into 7-bit digits, least significant first
      rest = ev.delta_ticks;
      ndig = 0;
      do begin
         digits[ndig] = rest[VLQ_DIGIT_W-1:0];
         rest         = rest >> VLQ_DIGIT_W;
         ndig++;
      end while (rest != '0 && ndig < VLQ_MAX_DIGITS);

      // emit most significant digit first, continuation bit on all but last
      cnt = 0;
      for (int i = ndig - 1; i >= 0; i--) begin
         seq[cnt] = {(i != 0), digits[i]};
         cnt++;
      end

      case (ev.action)
         ACTION_NOTE_ON: begin
            seq[cnt]   = STATUS_NOTE_ON;
            seq[cnt+1] = {1'b0, ev.note_number};
            seq[cnt+2] = {1'b0, ev.note_velocity};
            cnt += 3;
         end
         ACTION_NOTE_OFF: begin
            seq[cnt]   = STATUS_NOTE_OFF;
            seq[cnt+1] = {1'b0, ev.note_number};
            seq[cnt+2] = NOTE_OFF_VEL;
            cnt += 3;
         end
         default: begin
            seq[cnt]   = META_PREFIX;
            seq[cnt+1] = META_TEMPO;
            seq[cnt+2] = META_TEMPO_LEN;
            seq[cnt+3] = ev.tempo_us_per_beat[23:16];
            seq[cnt+4] = ev.tempo_us_per_beat[15:8];
            seq[cnt+5] = ev.tempo_us_per_beat[7:0];
            cnt += 6;
         end
      endcase

      for (int i = 0; i < cnt; i++)
         queue_expected({seq[i], (i == cnt - 1)});
   endfunction

   // Record what the run has covered for the closing summary
   function automatic void note_coverage(input req_payload_type ev);
      events_by_action[ev.action]++;
      if (ev.action != ACTION_UNDEFINED)
         delta_length_seen[1 + (ev.delta_ticks > 28'h7F) + (ev.delta_ticks > 28'h3FFF)
                           + (ev.delta_ticks > 28'h1FFFFF)]++;
   endfunction

   function automatic void report_mismatch(input string what, input rsp_payload_type want,
                                           input rsp_payload_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("[%0t] MISMATCH %s: expected byte %02h last %0b, got byte %02h last %0b",
                  $realtime, what, want.out_byte, want.last_byte, got.out_byte,
                  got.last_byte);
   endfunction

   // ------------------------------------------------------------------------
   // Request side: wait a random gap (or none during a burst), then hold the
   // event on the channel until the serializer takes it.
   // ------------------------------------------------------------------------
   task automatic send_event(input req_payload_type ev);
      int gap;

      if (send_burst_left > 0) begin
         gap = 0;
         send_burst_left--;
      end else begin
         gap = $urandom_range(0, MAX_GAP);
         if ($urandom_range(0, 15) == 0) send_burst_left = $urandom_range(8, 30);
      end

      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= ev;
      do @(posedge clock); while (!req_ch.ready);
      // the transaction happened at this edge
      note_coverage(ev);
   endtask

   // ------------------------------------------------------------------------
   // Byte side: stall a random number of cycles before each byte, with
   // occasional stretches of back-to-back acceptance.
   // ------------------------------------------------------------------------
   initial begin : byte_sink
      int stall;

      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (sink_burst_left > 0) begin
            stall = 0;
            sink_burst_left--;
         end else begin
            stall = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 15) == 0) sink_burst_left = $urandom_range(10, 40);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   // ------------------------------------------------------------------------
   // Checker: compare every accepted byte with the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : byte_checker
      rsp_payload_type want;

      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_track_bytes.size() == 0) begin
            report_mismatch("byte with nothing expected", '0, rsp_ch.payload);
         end else begin
            want = expected_track_bytes.pop_front();
            bytes_compared++;
            if (rsp_ch.payload.out_byte !== want.out_byte)
               report_mismatch("out_byte", want, rsp_ch.payload);
            else if (rsp_ch.payload.last_byte !== want.last_byte)
               report_mismatch("last_byte", want, rsp_ch.payload);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: end the run when no transaction happens for too long
   // ------------------------------------------------------------------------
   initial begin : watchdog
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus: directed events, then random ones, then drain and report
   // ------------------------------------------------------------------------
   initial begin : stimulus
      req_payload_type    ev;
      directed_event_type row;
      int                 sent;
      int                 pick;
      int                 span;

      mismatches      = 0;
      bytes_compared  = 0;
      send_burst_left = 0;
      sink_burst_left = 0;
      foreach (events_by_action[i]) events_by_action[i] = 0;
      foreach (delta_length_seen[i]) delta_length_seen[i] = 0;

      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      @(posedge clock);
      while (reset) @(posedge clock);

      // Walk the directed list; typed rows carry their own expected bytes
      for (int r = 0; r < NUM_DIRECTED; r++) begin
         row = DIRECTED_EVENTS[r];
         ev  = '{action: row.action, delta_ticks: row.delta, note_number: row.note,
                 note_velocity: row.vel, tempo_us_per_beat: row.tempo};
         send_event(ev);
         if (row.typed) begin
            for (int i = 0; i < row.typed_count; i++)
               queue_expected(
                  {row.typed_bytes[(row.typed_count - 1 - i) * BYTE_W +: BYTE_W],
                   (i == row.typed_count - 1)});
         end else begin
            predict_track_bytes(ev);
         end
      end

      // Random events, undefined codes mixed in
      sent = 0;
      while (sent < RANDOM_EVENTS) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)      ev.action = ACTION_UNDEFINED;
         else if (pick < 8)  ev.action = ACTION_NOTE_ON;
         else if (pick < 14) ev.action = ACTION_NOTE_OFF;
         else                ev.action = ACTION_TEMPO;

         // spread deltas over every VLQ length and its boundaries
         case ($urandom_range(0, 5))
            0: ev.delta_ticks = DELTA_W'($urandom_range(0, 28'h7F));
            1: ev.delta_ticks = DELTA_W'($urandom_range(28'h80, 28'h3FFF));
            2: ev.delta_ticks = DELTA_W'($urandom_range(28'h4000, 28'h1FFFFF));
            3: ev.delta_ticks = DELTA_W'($urandom_range(28'h200000, 28'hFFFFFFF));
            4: begin
               span = $urandom_range(1, VLQ_MAX_DIGITS) * VLQ_DIGIT_W;
               if (span == DELTA_W)
                  ev.delta_ticks = {DELTA_W{1'b1}};
               else
                  ev.delta_ticks = (DELTA_W'(1) << span)
                                   - DELTA_W'($urandom_range(0, 1));
            end
            default: ev.delta_ticks = DELTA_W'($urandom());
         endcase

         ev.note_number   = NOTE_W'($urandom());
         ev.note_velocity = VEL_W'($urandom());
         case ($urandom_range(0, 7))
            0:       ev.tempo_us_per_beat = '0;
            1:       ev.tempo_us_per_beat = '1;
            default: ev.tempo_us_per_beat = TEMPO_W'($urandom());
         endcase

         send_event(ev);
         predict_track_bytes(ev);
         sent++;
      end

      // Drop valid and let the remaining bytes drain, then watch for strays
      req_ch.valid <= 1'b0;
      while (expected_track_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Events: %0d note on, %0d note off, %0d tempo, %0d undefined; %0d bytes checked",
               events_by_action[ACTION_NOTE_ON], events_by_action[ACTION_NOTE_OFF],
               events_by_action[ACTION_TEMPO], events_by_action[ACTION_UNDEFINED],
               bytes_compared);
      $display("Delta lengths: 1 byte %0d, 2 bytes %0d, 3 bytes %0d, 4 bytes %0d; mismatches %0d",
               delta_length_seen[1], delta_length_seen[2], delta_length_seen[3],
               delta_length_seen[4], mismatches);

      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
